// ----- rtl/dsas_pkg.sv -----
// ============================================================================
// dsas_pkg: shared types and constants for the DAC sweep / ADC average unit
// Result kinds, register indexes, stream widths and register reset values.
// ============================================================================
package dsas_pkg;

    localparam int LEVEL_W     = 12;
    localparam int TICK_W      = 16;
    localparam int SMP_IN_W    = 12;
    localparam int MEAN_W      = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_END    = 2'd2,
        KIND_PARK   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MV     = 3'd0,
        REG_STEP_MV      = 3'd1,
        REG_STOP_MV      = 3'd2,
        REG_SETTLE_TICKS = 3'd3,
        REG_DWELL_TICKS  = 3'd4,
        REG_PARK_TICKS   = 3'd5,
        REG_PARK_MV      = 3'd6
    } reg_index_t;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 12'd4095;
    localparam logic [LEVEL_W-1:0] RST_START_MV   = 12'd20;
    localparam logic [LEVEL_W-1:0] RST_STEP_MV    = 12'd30;
    localparam logic [LEVEL_W-1:0] RST_STOP_MV    = 12'd2000;
    localparam logic [TICK_W-1:0]  RST_SETTLE     = 16'd90;
    localparam logic [TICK_W-1:0]  RST_DWELL      = 16'd100;
    localparam logic [TICK_W-1:0]  RST_PARK_TICKS = 16'd10000;
    localparam logic [LEVEL_W-1:0] RST_PARK_MV    = 12'd1;

endpackage

// ----- rtl/dsas_div.sv -----
// ============================================================================
// dsas_div: serial restoring divider
// One quotient bit per cycle; the quotient is known to fit QUO_W bits.
// ============================================================================
module dsas_div #(
    parameter int SUM_W = 28,
    parameter int CNT_W = 16,
    parameter int QUO_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);
    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // high part is below the divisor, so only QUO_W steps remain
            rem_next  = CNT_W'(dividend >> QUO_W);
            quo_next  = dividend[QUO_W-1:0];
            step_next = STEP_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/dac_sweep_adc_average_sequencer_unit.sv -----
// ============================================================================
// dac_sweep_adc_average_sequencer_unit: staircase DAC sweep with ADC averaging
// Tick and ADC-pair items drive a sweep sequencer; reports carry channel means.
// ============================================================================
// Each input transfer is either a timer tick (tuser = 0) or a completed ADC
// sample pair (tuser = 1), and each carries the notify-enable level. ADC pairs
// accumulate into two saturating sums. A tick advances the sweep: it may start
// the sweep, command the DACs (kind 0), report the truncated means of the
// samples taken since the step began (kind 1), raise the level, end the sweep
// with an end marker (kind 2) followed by a park command (kind 3), or close
// the park once it expires. Each result waits for a free output register; a
// report with samples runs both channels in turn through one shared serial
// divider, one quotient bit per cycle. The input is not ready while an item
// is being worked on. Results leave through an output register, so the next
// item may be accepted while the last result still waits for m_tready.
// Configuration writes are taken at any time but are meant for an idle block.
// ============================================================================
module dac_sweep_adc_average_sequencer_unit #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: enabled[0], sample_a[12:1], sample_b[24:13], zero fill
    input  logic [dsas_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tuser: op[0]
    input  logic [dsas_pkg::IN_TUSER_W-1:0]   s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: level_mv[11:0], mean_a[23:12], mean_b[35:24], no_samples[36]
    output logic [dsas_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // tuser: kind[1:0]
    output logic [dsas_pkg::OUT_TUSER_W-1:0]  m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dsas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsas_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dsas_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam int QUO_W = SAMPLE_BITS + 1;
    localparam int CMP_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0]      SUM_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_WAIT_A,
        ST_LOAD_B,
        ST_WAIT_B,
        ST_EMIT,
        ST_EMIT_END
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [LEVEL_W-1:0] start_mv_reg, step_mv_reg, stop_mv_reg, park_mv_reg;
    logic [TICK_W-1:0]  settle_ticks_reg, dwell_ticks_reg, park_ticks_reg;

    // sequencer state
    logic                  active_reg, active_next;
    logic                  parked_reg, parked_next;
    logic                  samp_open_reg, samp_open_next;
    logic                  step_open_reg, step_open_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [COUNT_BITS-1:0] settle_cnt_reg, settle_cnt_next;
    logic [COUNT_BITS-1:0] dwell_cnt_reg, dwell_cnt_next;
    logic [COUNT_BITS-1:0] park_cnt_reg, park_cnt_next;
    logic [SUM_W-1:0]      sum_a_reg, sum_a_next;
    logic [SUM_W-1:0]      sum_b_reg, sum_b_next;
    logic [COUNT_BITS-1:0] smp_cnt_reg, smp_cnt_next;

    // pending result
    kind_t              pend_kind_reg, pend_kind_next;
    logic [LEVEL_W-1:0] pend_level_reg, pend_level_next;
    logic [MEAN_W-1:0]  mean_a_reg, mean_a_next;
    logic [MEAN_W-1:0]  mean_b_reg, mean_b_next;
    logic               pend_ns_reg, pend_ns_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic                   out_last_reg, out_last_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // input decode
    logic                   in_op;
    logic                   in_en;
    logic [SAMPLE_BITS-1:0] smp_a, smp_b;
    logic                   in_xfer;
    logic                   out_free;
    logic [SUM_W:0]         add_a, add_b;
    logic [LEVEL_W:0]       level_sum;
    logic                   settle_gt, dwell_gt, park_gt;
    // counter bases after a possible clear in this tick
    logic [COUNT_BITS-1:0]  settle_base, dwell_base, park_base;

    // divider hookup
    logic                   div_start;
    logic [SUM_W-1:0]       div_dividend;
    logic                   div_done;
    logic [QUO_W-1:0]       div_quotient;

    assign in_op   = s_tuser[0];
    assign in_en   = s_tdata[0];
    assign smp_a   = SAMPLE_BITS'(s_tdata[SMP_IN_W:1]);
    assign smp_b   = SAMPLE_BITS'(s_tdata[2*SMP_IN_W:SMP_IN_W+1]);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign add_a     = {1'b0, sum_a_reg} + (SUM_W + 1)'(smp_a);
    assign add_b     = {1'b0, sum_b_reg} + (SUM_W + 1)'(smp_b);
    assign level_sum = {1'b0, level_reg} + {1'b0, step_mv_reg};

    assign settle_gt = CMP_W'(settle_cnt_reg) > CMP_W'(settle_ticks_reg);
    assign dwell_gt  = CMP_W'(dwell_cnt_reg)  > CMP_W'(dwell_ticks_reg);
    assign park_gt   = CMP_W'(park_cnt_reg)   > CMP_W'(park_ticks_reg);

    assign div_start    = (state_reg == ST_LOAD_A) || (state_reg == ST_LOAD_B);
    assign div_dividend = (state_reg == ST_LOAD_B) ? sum_b_reg : sum_a_reg;

    dsas_div #(
        .SUM_W (SUM_W),
        .CNT_W (COUNT_BITS),
        .QUO_W (QUO_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (smp_cnt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        parked_next     = parked_reg;
        samp_open_next  = samp_open_reg;
        step_open_next  = step_open_reg;
        level_next      = level_reg;
        settle_cnt_next = settle_cnt_reg;
        dwell_cnt_next  = dwell_cnt_reg;
        park_cnt_next   = park_cnt_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        smp_cnt_next    = smp_cnt_reg;
        pend_kind_next  = pend_kind_reg;
        pend_level_next = pend_level_reg;
        mean_a_next     = mean_a_reg;
        mean_b_next     = mean_b_reg;
        pend_ns_next    = pend_ns_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_data_next   = out_data_reg;
        settle_base     = settle_cnt_reg;
        dwell_base      = dwell_cnt_reg;
        park_base       = park_cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_op)
                begin
                    // accumulate the pair whatever the sweep is doing
                    sum_a_next   = add_a[SUM_W] ? SUM_MAX : add_a[SUM_W-1:0];
                    sum_b_next   = add_b[SUM_W] ? SUM_MAX : add_b[SUM_W-1:0];
                    smp_cnt_next = (smp_cnt_reg == CNT_MAX) ? CNT_MAX
                                   : smp_cnt_reg + COUNT_BITS'(1);
                end
                else if (in_xfer)
                begin
                    if (!active_reg && in_en)
                    begin
                        active_next = 1'b1;
                        parked_next = 1'b0;
                        level_next  = start_mv_reg;
                    end
                    else if (active_reg && in_en && !parked_reg
                             && level_reg <= stop_mv_reg)
                    begin
                        if (!samp_open_reg && !step_open_reg)
                        begin
                            // new step: command DACs and open sampling
                            pend_kind_next  = KIND_SET;
                            pend_level_next = level_reg;
                            mean_a_next     = '0;
                            mean_b_next     = '0;
                            pend_ns_next    = 1'b0;
                            settle_base     = '0;
                            dwell_base      = '0;
                            sum_a_next      = '0;
                            sum_b_next      = '0;
                            smp_cnt_next    = '0;
                            step_open_next  = 1'b1;
                            samp_open_next  = 1'b1;
                            state_next      = ST_EMIT;
                        end
                        else if (settle_gt && samp_open_reg && step_open_reg)
                        begin
                            samp_open_next  = 1'b0;
                            pend_kind_next  = KIND_REPORT;
                            pend_level_next = level_reg;
                            mean_a_next     = '0;
                            mean_b_next     = '0;
                            pend_ns_next    = 1'b1;
                            // sums are cleared once the divider is through
                            if (smp_cnt_reg != '0)
                            begin
                                state_next = ST_LOAD_A;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        else if (!samp_open_reg && dwell_gt && step_open_reg)
                        begin
                            step_open_next = 1'b0;
                            level_next     = level_sum[LEVEL_W] ? LEVEL_MAX
                                             : level_sum[LEVEL_W-1:0];
                        end
                    end
                    else if (active_reg && in_en && !parked_reg)
                    begin
                        // end marker first, then the park command
                        pend_kind_next  = KIND_PARK;
                        pend_level_next = park_mv_reg;
                        mean_a_next     = '0;
                        mean_b_next     = '0;
                        pend_ns_next    = 1'b0;
                        park_base       = '0;
                        parked_next     = 1'b1;
                        state_next      = ST_EMIT_END;
                    end
                    else if (park_gt && active_reg && in_en && parked_reg)
                    begin
                        active_next = 1'b0;
                    end

                    // every tick advances all three counters
                    settle_cnt_next = (settle_base == CNT_MAX) ? CNT_MAX
                                      : settle_base + COUNT_BITS'(1);
                    dwell_cnt_next  = (dwell_base == CNT_MAX) ? CNT_MAX
                                      : dwell_base + COUNT_BITS'(1);
                    park_cnt_next   = (park_base == CNT_MAX) ? CNT_MAX
                                      : park_base + COUNT_BITS'(1);
                end
            end

            ST_LOAD_A:
            begin
                state_next = ST_WAIT_A;
            end

            ST_WAIT_A:
            begin
                if (div_done)
                begin
                    mean_a_next = MEAN_W'(div_quotient);
                    state_next  = ST_LOAD_B;
                end
            end

            ST_LOAD_B:
            begin
                state_next = ST_WAIT_B;
            end

            ST_WAIT_B:
            begin
                if (div_done)
                begin
                    mean_b_next  = MEAN_W'(div_quotient);
                    pend_ns_next = 1'b0;
                    sum_a_next   = '0;
                    sum_b_next   = '0;
                    smp_cnt_next = '0;
                    state_next   = ST_EMIT;
                end
            end

            ST_EMIT_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_END;
                    out_last_next  = 1'b0;
                    out_data_next  = '0;
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_last_next  = 1'b1;
                    out_data_next  = OUT_TDATA_W'({pend_ns_reg, mean_b_reg,
                                                   mean_a_reg, pend_level_reg});
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            parked_reg     <= 1'b0;
            samp_open_reg  <= 1'b0;
            step_open_reg  <= 1'b0;
            level_reg      <= '0;
            settle_cnt_reg <= '0;
            dwell_cnt_reg  <= '0;
            park_cnt_reg   <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            smp_cnt_reg    <= '0;
            pend_kind_reg  <= KIND_SET;
            pend_level_reg <= '0;
            mean_a_reg     <= '0;
            mean_b_reg     <= '0;
            pend_ns_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_SET;
            out_last_reg   <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            parked_reg     <= parked_next;
            samp_open_reg  <= samp_open_next;
            step_open_reg  <= step_open_next;
            level_reg      <= level_next;
            settle_cnt_reg <= settle_cnt_next;
            dwell_cnt_reg  <= dwell_cnt_next;
            park_cnt_reg   <= park_cnt_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            smp_cnt_reg    <= smp_cnt_next;
            pend_kind_reg  <= pend_kind_next;
            pend_level_reg <= pend_level_next;
            mean_a_reg     <= mean_a_next;
            mean_b_reg     <= mean_b_next;
            pend_ns_reg    <= pend_ns_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_last_reg   <= out_last_next;
            out_data_reg   <= out_data_next;
        end
    end

    // configuration write channel; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_mv_reg     <= RST_START_MV;
            step_mv_reg      <= RST_STEP_MV;
            stop_mv_reg      <= RST_STOP_MV;
            settle_ticks_reg <= RST_SETTLE;
            dwell_ticks_reg  <= RST_DWELL;
            park_ticks_reg   <= RST_PARK_TICKS;
            park_mv_reg      <= RST_PARK_MV;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_MV:     start_mv_reg     <= cfg_data[LEVEL_W-1:0];
                REG_STEP_MV:      step_mv_reg      <= cfg_data[LEVEL_W-1:0];
                REG_STOP_MV:      stop_mv_reg      <= cfg_data[LEVEL_W-1:0];
                REG_SETTLE_TICKS: settle_ticks_reg <= cfg_data[TICK_W-1:0];
                REG_DWELL_TICKS:  dwell_ticks_reg  <= cfg_data[TICK_W-1:0];
                REG_PARK_TICKS:   park_ticks_reg   <= cfg_data[TICK_W-1:0];
                REG_PARK_MV:      park_mv_reg      <= cfg_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- bench/dac_sweep_adc_average_sequencer_unit_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// dac_sweep_adc_average_sequencer_unit_tb: sweep sequencer stream bench
// Sends tick and ADC-pair transfers under several register settings, tracks
// the sweep in a software copy and compares every output transfer against it.
// ============================================================================
// Flow: a short directed run under the reset settings walks one sweep through
// start, DAC set, sample collection and a disabled tick; a second directed run
// with zero wait times hits reports with and without samples, level
// saturation, the end marker with park, a parked disabled tick and the park
// expiry. Random phases follow, each with its own register setting, mostly
// enabled ticks mixed with ADC pairs so the sweep actually steps, ends, parks
// and restarts. Backpressure on both sides is set per phase pair; one phase
// holds off the output side for a long stretch to fill the block up.
// ============================================================================
module dac_sweep_adc_average_sequencer_unit_tb;
    import dsas_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_W       = SAMPLE_BITS + COUNT_BITS;

    localparam logic [SUM_W-1:0]      SUM_MAX = {SUM_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // input item kinds, carried on s_tuser
    localparam bit OP_TICK = 1'b0;
    localparam bit OP_ADC  = 1'b1;

    // cycles to let pass once nothing is expected (serial divider plus slack)
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        kind_t              kind;
        logic [LEVEL_W-1:0] level_mv;
        logic [MEAN_W-1:0]  mean_a;
        logic [MEAN_W-1:0]  mean_b;
        logic               no_samples;
        logic               last;
    } sweep_result_t;

    // ------------------------------------------------------------------------
    // Sweep tracker: software copy of the sequencer plus the queue of results
    // it has predicted but not yet seen on the output stream.
    // ------------------------------------------------------------------------
    class sweep_tracker;
        logic [LEVEL_W-1:0]    start_mv, step_mv, stop_mv, park_mv;
        logic [TICK_W-1:0]     settle_ticks, dwell_ticks, park_ticks;
        bit                    sweep_active, parked, sampling_open, step_open;
        logic [LEVEL_W-1:0]    level;
        logic [COUNT_BITS-1:0] settle_count, dwell_count, park_count, sample_count;
        logic [SUM_W-1:0]      sum_a, sum_b;
        sweep_result_t         pending_results[$];
        int                    mismatches;

        function new();
            start_mv      = RST_START_MV;
            step_mv       = RST_STEP_MV;
            stop_mv       = RST_STOP_MV;
            settle_ticks  = RST_SETTLE;
            dwell_ticks   = RST_DWELL;
            park_ticks    = RST_PARK_TICKS;
            park_mv       = RST_PARK_MV;
            sweep_active  = 0;
            parked        = 0;
            sampling_open = 0;
            step_open     = 0;
            level         = '0;
            settle_count  = '0;
            dwell_count   = '0;
            park_count    = '0;
            sample_count  = '0;
            sum_a         = '0;
            sum_b         = '0;
            mismatches    = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_START_MV:     start_mv = value[LEVEL_W-1:0];
                REG_STEP_MV:      step_mv = value[LEVEL_W-1:0];
                REG_STOP_MV:      stop_mv = value[LEVEL_W-1:0];
                REG_SETTLE_TICKS: settle_ticks = value[TICK_W-1:0];
                REG_DWELL_TICKS:  dwell_ticks = value[TICK_W-1:0];
                REG_PARK_TICKS:   park_ticks = value[TICK_W-1:0];
                REG_PARK_MV:      park_mv = value[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        function sweep_result_t make_result(kind_t k, logic [LEVEL_W-1:0] lv,
                                            logic [MEAN_W-1:0] ma,
                                            logic [MEAN_W-1:0] mb, logic ns);
            sweep_result_t r;
            r.kind       = k;
            r.level_mv   = lv;
            r.mean_a     = ma;
            r.mean_b     = mb;
            r.no_samples = ns;
            r.last       = 1'b0;
            return r;
        endfunction

        // Advance the sweep by one accepted input transfer.
        function void note_item(bit is_adc, bit en, logic [SMP_IN_W-1:0] smp_a,
                                logic [SMP_IN_W-1:0] smp_b);
            sweep_result_t    produced[$];
            logic [SUM_W:0]   wide;
            logic [SUM_W-1:0] quot_a, quot_b;
            logic [LEVEL_W:0] next_level;

            // ADC pairs only accumulate, whatever the sequencer is doing
            if (is_adc) begin
                wide  = sum_a + smp_a;
                sum_a = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
                wide  = sum_b + smp_b;
                sum_b = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
                sample_count = bump(sample_count);
                return;
            end

            // one branch per tick: start, step action, sweep end, park expiry
            if (!sweep_active && en) begin
                sweep_active = 1;
                parked       = 0;
                level        = start_mv;
            end else if (sweep_active && en && !parked && level <= stop_mv) begin
                if (!sampling_open && !step_open) begin
                    produced.push_back(make_result(KIND_SET, level, '0, '0, 1'b0));
                    settle_count  = '0;
                    dwell_count   = '0;
                    sample_count  = '0;
                    sum_a         = '0;
                    sum_b         = '0;
                    step_open     = 1;
                    sampling_open = 1;
                end else if (settle_count > settle_ticks && sampling_open && step_open)
                begin
                    sampling_open = 0;
                    if (sample_count != 0) begin
                        quot_a = sum_a / sample_count;
                        quot_b = sum_b / sample_count;
                        produced.push_back(make_result(KIND_REPORT, level,
                            quot_a[MEAN_W-1:0], quot_b[MEAN_W-1:0], 1'b0));
                    end else begin
                        produced.push_back(make_result(KIND_REPORT, level, '0, '0, 1'b1));
                    end
                    sample_count = '0;
                    sum_a        = '0;
                    sum_b        = '0;
                end else if (!sampling_open && dwell_count > dwell_ticks && step_open)
                begin
                    step_open  = 0;
                    next_level = level + step_mv;
                    level      = (next_level > LEVEL_MAX) ? LEVEL_MAX
                                                          : next_level[LEVEL_W-1:0];
                end
            end else if (sweep_active && en && !parked) begin
                produced.push_back(make_result(KIND_END, '0, '0, '0, 1'b0));
                park_count = '0;
                produced.push_back(make_result(KIND_PARK, park_mv, '0, '0, 1'b0));
                parked = 1;
            end else if (park_count > park_ticks && sweep_active && en && parked) begin
                sweep_active = 0;
            end

            // every tick advances all three counters, disabled or not
            park_count   = bump(park_count);
            settle_count = bump(settle_count);
            dwell_count  = bump(dwell_count);

            if (produced.size() > 0)
                produced[produced.size()-1].last = 1'b1;
            foreach (produced[i])
                pending_results.push_back(produced[i]);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Match one output transfer against the oldest predicted result.
        function void check_result(logic [OUT_TDATA_W-1:0] data,
                                   logic [OUT_TUSER_W-1:0] user, logic tl);
            sweep_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d level %0d",
                         $time, user, data[11:0]);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", want.kind, user);
            compare_field("level_mv", want.level_mv, data[11:0]);
            compare_field("mean_a", want.mean_a, data[23:12]);
            compare_field("mean_b", want.mean_b, data[35:24]);
            compare_field("no_samples", want.no_samples, data[36]);
            compare_field("last", want.last, tl);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;   // enabled[0], sample_a[12:1], sample_b[24:13]
    logic [IN_TUSER_W-1:0]  s_tuser;   // op[0]
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // level_mv[11:0], mean_a[23:12], mean_b[35:24],
                                       // no_samples[36]
    logic [OUT_TUSER_W-1:0] m_tuser;   // kind[1:0]
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sweep_tracker tracker;
    int           tx_idle_pct;
    int           rx_idle_pct;
    bit           hold_off_req;

    dac_sweep_adc_average_sequencer_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // The watchdog ends the run as a failure if it has not finished by its time limit.
    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Output side: drop tready at random per the current phase; on request,
    // hold it low for a long stretch so the block backs up into its input.
    initial
    begin
        int hold_cnt;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                begin
                    m_tready <= 1'b0;
                    @(negedge clk);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Check each output transfer at the edge that completes it.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            tracker.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Present one input item, idling first at random; called and left at a
    // falling edge. tvalid stays high for a back-to-back transfer.
    task automatic send_item(bit is_adc, bit en, logic [SMP_IN_W-1:0] smp_a,
                             logic [SMP_IN_W-1:0] smp_b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_adc;
        s_tdata  <= {7'd0, smp_b, smp_a, en};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_item(is_adc, en, smp_a, smp_b);
        @(negedge clk);
    endtask

    // Wait out every expected result, then the block's own latency.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(idx, value);
        @(negedge clk);
    endtask

    // Load a full register setting; only called on an idle block.
    task automatic apply_setup(int start_v, int step_v, int stop_v, int settle_v,
                               int dwell_v, int park_v, int park_mv_v);
        write_reg(REG_START_MV, CFG_DATA_W'(start_v));
        write_reg(REG_STEP_MV, CFG_DATA_W'(step_v));
        write_reg(REG_STOP_MV, CFG_DATA_W'(stop_v));
        write_reg(REG_SETTLE_TICKS, CFG_DATA_W'(settle_v));
        write_reg(REG_DWELL_TICKS, CFG_DATA_W'(dwell_v));
        write_reg(REG_PARK_TICKS, CFG_DATA_W'(park_v));
        write_reg(REG_PARK_MV, CFG_DATA_W'(park_mv_v));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SMP_IN_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SMP_IN_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Mostly enabled ticks with sample pairs mixed in, so sweeps progress;
    // the odd disabled item stays in as noise.
    task automatic run_random(int count);
        bit is_adc;
        bit en;
        for (int i = 0; i < count; i++)
        begin
            is_adc = ($urandom_range(0, 99) < 45);
            en     = ($urandom_range(0, 99) < 92);
            send_item(is_adc, en, rand_sample(), rand_sample());
        end
    endtask

    initial
    begin
        int lo;
        tracker      = new();
        hold_off_req = 0;
        tx_idle_pct  = 26;
        rx_idle_pct  = 59;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: samples before any sweep, a disabled tick while
        // idle, start, DAC set at the reset start level, then samples and a
        // disabled tick while sampling is open.
        send_item(OP_ADC, 1'b0, 12'hFFF, 12'h000);
        send_item(OP_ADC, 1'b0, 12'h000, 12'hFFF);
        send_item(OP_TICK, 1'b0, 12'h000, 12'h000);
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);
        send_item(OP_ADC, 1'b1, 12'hFFF, 12'hFFF);
        send_item(OP_ADC, 1'b0, 12'h555, 12'hAAA);
        send_item(OP_TICK, 1'b0, 12'hAAA, 12'h555);
        wait_drained();

        // Zero waits and a level step that saturates past the stop level.
        apply_setup(4094, 4095, 4094, 0, 0, 0, 4095);
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);  // report with two samples
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);  // level saturates
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);  // end marker and park
        send_item(OP_TICK, 1'b0, 12'h000, 12'h000);  // disabled while parked
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);  // park expires
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);  // restart
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);  // DAC set
        send_item(OP_ADC, 1'b1, 12'h000, 12'h000);
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);  // report, mean zero
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);  // end and park
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);
        send_item(OP_TICK, 1'b1, 12'h000, 12'h000);  // report with no samples
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            // sender idles lightly first, then the other way round, then neither
            case (phase / 2)
                0:       begin tx_idle_pct = 26; rx_idle_pct = 59; end
                1:       begin tx_idle_pct = 59; rx_idle_pct = 26; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            case (phase)
                0: apply_setup(0, 4095, 0, 0, 0, 0, 4095);
                1: apply_setup(4095, 1, 4095, 3, 65535, 65535, 0);
                3: apply_setup(1000, 0, 2000, $urandom_range(0, 6),
                               $urandom_range(0, 10), $urandom_range(0, 8),
                               $urandom_range(0, 4095));
                default:
                begin
                    lo = $urandom_range(0, 3000);
                    apply_setup(lo, $urandom_range(40, 500), lo + $urandom_range(0, 1095),
                                $urandom_range(0, 6), $urandom_range(0, 10),
                                $urandom_range(0, 8), $urandom_range(0, 4095));
                end
            endcase
            if (phase == 4)
                hold_off_req = 1;
            run_random(phase == 1 ? 60 : (phase == 0 ? 120 : 140));
            wait_drained();
        end

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
